@@ rtl/core/tced_pkg.sv @@
// ----------------------------------------------------------------------------
// Telemetry change event detector package
// Shared types, event codes and slot layout for the detector and its checker.
// ----------------------------------------------------------------------------
package tced_pkg;

  localparam int unsigned ErrBits   = 8;
  localparam int unsigned Slots     = ErrBits + 4;
  localparam int unsigned SlotW     = $clog2(Slots);
  localparam int unsigned CodeW     = 4;
  localparam int unsigned BatW      = 7;
  localparam int unsigned InDataW   = 80;
  localparam int unsigned OutDataW  = 72;

  localparam logic [SlotW-1:0] SLOT_VEH   = SlotW'(ErrBits);
  localparam logic [SlotW-1:0] SLOT_LOCK  = SlotW'(ErrBits + 1);
  localparam logic [SlotW-1:0] SLOT_BAT   = SlotW'(ErrBits + 2);
  localparam logic [SlotW-1:0] SLOT_SOLAR = SlotW'(ErrBits + 3);

  localparam logic [CodeW-1:0] CODE_VEH_IN  = 4'd8;
  localparam logic [CodeW-1:0] CODE_VEH_OUT = 4'd9;
  localparam logic [CodeW-1:0] CODE_RAISED  = 4'd10;
  localparam logic [CodeW-1:0] CODE_LOWERED = 4'd11;
  localparam logic [CodeW-1:0] CODE_BAT_LOW = 4'd12;
  localparam logic [CodeW-1:0] CODE_SOLAR   = 4'd13;

  localparam logic [1:0] REG_BAT_LOW = 2'd0;
  localparam logic [1:0] REG_RAISED  = 2'd1;
  localparam logic [1:0] REG_LOWERED = 2'd2;

  localparam logic [BatW-1:0] BAT_DEFAULT     = 7'd100;
  localparam logic [BatW-1:0] BAT_LOW_RESET   = 7'd20;
  localparam logic [7:0]      RAISED_RESET    = 8'd1;
  localparam logic [7:0]      LOWERED_RESET   = 8'd0;
  localparam logic [7:0]      UNKNOWN_DEFAULT = 8'hFF;

  typedef struct packed {
    logic [ErrBits-1:0] err;
    logic [7:0]         veh;
    logic [7:0]         lock;
    logic [BatW-1:0]    bat;
    logic               solar;
  } status_t;

  typedef struct packed {
    logic [BatW-1:0] bat_low;
    logic [7:0]      raised;
    logic [7:0]      lowered;
  } cfg_t;

  typedef struct packed {
    logic [Slots-1:0] pend;
    logic             veh_present;
    logic             lock_raised;
  } detect_t;

endpackage

@@ rtl/core/telemetry_change_event_detector.sv @@
// ----------------------------------------------------------------------------
// Telemetry change event detector
// Turns status snapshots into an ordered run of change events.
// ----------------------------------------------------------------------------
// Each accepted snapshot is compared with the previous one in its acceptance
// cycle, and a sequencer then walks the twelve event slots up to its last
// event, one slot per cycle while no event waits on a held output register,
// in the order new error bits (bit 7 first), vehicle, lock, battery low and
// solar start. A snapshot that causes events stalls the input until its last
// event is loaded into the output register; one that causes no event does
// not stall it. The final beat of a run carries tlast. Configuration writes
// are always taken.
module telemetry_change_event_detector (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // err_in[7:0], vehicle_in[15:8], lock_in[23:16], battery_in[30:24],
  // solar_in[31], angle_in[47:32], time_in[79:48]
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // event_code[3:0], evt_time[35:4], evt_battery[42:36], evt_angle[58:43],
  // evt_errors[66:59], zero pad[71:67]
  output logic [71:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  tced_pkg::cfg_t    cfg;
  tced_pkg::status_t prev;
  tced_pkg::status_t cur;
  tced_pkg::detect_t det;
  tced_pkg::detect_t run;
  logic              have_previous;

  logic [31:0]                  snap_time;
  logic signed [15:0]           snap_angle;
  logic [tced_pkg::BatW-1:0]    snap_bat;
  logic [tced_pkg::ErrBits-1:0] snap_err;
  logic [tced_pkg::SlotW-1:0]   idx;

  logic [tced_pkg::Slots-1:0] shifted;
  logic                       more;
  logic                       out_free;
  logic                       fire;
  logic                       advance;
  logic                       accept;
  logic [tced_pkg::CodeW-1:0] code;
  logic [tced_pkg::ErrBits-1:0] errs;

  logic [tced_pkg::CodeW-1:0]   o_code;
  logic [31:0]                  o_time;
  logic [tced_pkg::BatW-1:0]    o_bat;
  logic signed [15:0]           o_angle;
  logic [tced_pkg::ErrBits-1:0] o_errs;

  assign cur.err   = s_tdata[7:0];
  assign cur.veh   = s_tdata[15:8];
  assign cur.lock  = s_tdata[23:16];
  assign cur.bat   = s_tdata[30:24];
  assign cur.solar = s_tdata[31];

  tced_detect u_detect (
    .cur           (cur),
    .prev          (prev),
    .have_previous (have_previous),
    .cfg           (cfg),
    .det           (det)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign accept    = s_tvalid && s_tready;

  assign shifted  = run.pend >> idx;
  assign more     = |shifted[tced_pkg::Slots-1:1];
  assign out_free = !m_tvalid || m_tready;
  assign fire     = (state == ST_SCAN) && run.pend[idx] && out_free;
  assign advance  = (state == ST_SCAN) && (!run.pend[idx] || out_free);

  always_comb begin
    case (idx)
      tced_pkg::SLOT_VEH:   code = run.veh_present ? tced_pkg::CODE_VEH_IN
                                                   : tced_pkg::CODE_VEH_OUT;
      tced_pkg::SLOT_LOCK:  code = run.lock_raised ? tced_pkg::CODE_RAISED
                                                   : tced_pkg::CODE_LOWERED;
      tced_pkg::SLOT_BAT:   code = tced_pkg::CODE_BAT_LOW;
      tced_pkg::SLOT_SOLAR: code = tced_pkg::CODE_SOLAR;
      default:              code = tced_pkg::CodeW'(idx);
    endcase
  end

  // Error flags read as zero from the vehicle slot on when the run holds a vehicle event.
  assign errs = (run.pend[tced_pkg::SLOT_VEH] && idx >= tced_pkg::SLOT_VEH) ? '0 : snap_err;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && (|det.pend)) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (advance && !more) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      have_previous <= 1'b0;
      prev.err      <= '0;
      prev.veh      <= '0;
      prev.lock     <= '0;
      prev.bat      <= tced_pkg::BAT_DEFAULT;
      prev.solar    <= 1'b0;
      cfg.bat_low   <= tced_pkg::BAT_LOW_RESET;
      cfg.raised    <= tced_pkg::RAISED_RESET;
      cfg.lowered   <= tced_pkg::LOWERED_RESET;
      m_tvalid      <= 1'b0;
      idx           <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tced_pkg::REG_BAT_LOW: cfg.bat_low <= cfg_data[tced_pkg::BatW-1:0];
          tced_pkg::REG_RAISED:  cfg.raised  <= cfg_data;
          tced_pkg::REG_LOWERED: cfg.lowered <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        prev          <= cur;
        have_previous <= 1'b1;
        idx           <= '0;
      end else if (advance && more) begin
        idx <= idx + 1'b1;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      run        <= det;
      snap_err   <= cur.err;
      snap_bat   <= cur.bat;
      snap_angle <= s_tdata[47:32];
      snap_time  <= s_tdata[79:48];
    end
    if (fire) begin
      o_code  <= code;
      o_time  <= snap_time;
      o_bat   <= snap_bat;
      o_angle <= snap_angle;
      o_errs  <= errs;
      m_tlast <= !more;
    end
  end

  assign m_tdata = {5'd0, o_errs, o_angle, o_bat, o_time, o_code};

endmodule

@@ rtl/core/tced_detect.sv @@
// ----------------------------------------------------------------------------
// Change detector
// Compares a snapshot with the previous one (or with defaults before the first) and marks the events it causes.
// ----------------------------------------------------------------------------
module tced_detect (
  input  tced_pkg::status_t cur,
  input  tced_pkg::status_t prev,
  input  logic              have_previous,
  input  tced_pkg::cfg_t    cfg,
  output tced_pkg::detect_t det
);

  tced_pkg::status_t ref_st;
  logic [tced_pkg::ErrBits-1:0] fresh;
  logic lock_hit_r;
  logic lock_hit_l;

  always_comb begin
    if (have_previous) begin
      ref_st = prev;
    end else begin
      ref_st.err   = '0;
      ref_st.veh   = tced_pkg::UNKNOWN_DEFAULT;
      ref_st.lock  = tced_pkg::UNKNOWN_DEFAULT;
      ref_st.bat   = tced_pkg::BAT_DEFAULT;
      ref_st.solar = 1'b0;
    end
  end

  assign fresh      = cur.err & ~ref_st.err;
  assign lock_hit_r = (cur.lock == cfg.raised);
  assign lock_hit_l = (cur.lock == cfg.lowered);

  // Slot i below the error count holds error bit (ErrBits-1-i).
  always_comb begin
    det.pend = '0;
    for (int i = 0; i < tced_pkg::ErrBits; i++) begin
      det.pend[i] = fresh[tced_pkg::ErrBits-1-i];
    end
    det.pend[tced_pkg::SLOT_VEH]   = (cur.veh != ref_st.veh);
    det.pend[tced_pkg::SLOT_LOCK]  = (cur.lock != ref_st.lock) && (lock_hit_r || lock_hit_l);
    det.pend[tced_pkg::SLOT_BAT]   = (ref_st.bat > cfg.bat_low) && (cur.bat <= cfg.bat_low);
    det.pend[tced_pkg::SLOT_SOLAR] = !ref_st.solar && cur.solar;
    det.veh_present = (cur.veh != 8'd0);
    det.lock_raised = lock_hit_r;
  end

endmodule

@@ rtl/core/tced_checker.sv @@
// ----------------------------------------------------------------------------
// Telemetry change event detector checker
// Port-level checks on the detector, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tced_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast,
  input logic        cfg_ready
);

  // A held beat keeps its payload until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // No new snapshot is taken while a run still has beats to come.
  a_run_blocks_input: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready in the middle of an event run");

  // Vehicle events always carry cleared error flags.
  a_vehicle_errors: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[3:0] == tced_pkg::CODE_VEH_IN ||
                 m_tdata[3:0] == tced_pkg::CODE_VEH_OUT) |-> m_tdata[66:59] == 8'd0)
    else $error("vehicle event with error flags set");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[3:0] <= tced_pkg::CODE_SOLAR && m_tdata[71:67] == 5'd0)
    else $error("event code or padding out of range");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_ready)
    else $error("configuration channel not ready");

endmodule

bind telemetry_change_event_detector tced_checker u_tced_checker (
  .clk       (clk),
  .rst       (rst),
  .s_tready  (s_tready),
  .m_tvalid  (m_tvalid),
  .m_tready  (m_tready),
  .m_tdata   (m_tdata),
  .m_tlast   (m_tlast),
  .cfg_ready (cfg_ready)
);
